// ===== sv/bwbv_pkg.sv =====
package bwbv_pkg;

   localparam int DelayDepth = 4096;
   localparam int AddrBits   = $clog2(DelayDepth);
   localparam int BandCount  = 4;
   localparam int BandBits   = $clog2(BandCount);
   localparam int SampleBits = 24;
   localparam int SetupBits  = 57;

   localparam logic [31:0] NoiseSeed = 32'h9d2c5681;
   localparam logic [19:0] LenMax    = 20'((DelayDepth - 2) * 256);
   localparam logic [4:0]  DivLast   = 5'd19;

   // register indexes (byte address bits [5:3])
   localparam logic [2:0] RegBand0    = 3'd0;
   localparam logic [2:0] RegBand1    = 3'd1;
   localparam logic [2:0] RegBand2    = 3'd2;
   localparam logic [2:0] RegBand3    = 3'd3;
   localparam logic [2:0] RegLoopGain = 3'd4;
   localparam logic [2:0] RegBowForce = 3'd5;

   typedef enum logic [5:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_TERM, OP_SLOPE1, OP_SLOPE2, OP_XLOAD,
      OP_DIVINIT, OP_DIVSTEP, OP_R2, OP_R4, OP_FRIC, OP_EX1, OP_EX2, OP_EX3,
      OP_NZ1, OP_NZ2, OP_NZ3, OP_BADDR, OP_BRD1, OP_BRD2, OP_BINT,
      OP_F1, OP_F2, OP_F3, OP_F4, OP_W1, OP_W2, OP_W3, OP_W4, OP_W5,
      OP_OUT1, OP_EMIT
   } op_type;

   typedef enum logic [5:0] {
      ST_INIT_CLR, ST_IDLE, ST_NOTE_CLR, ST_PRESS_CHK, ST_TERM, ST_SLOPE1,
      ST_SLOPE2, ST_XLOAD, ST_DIVINIT, ST_DIVSTEP, ST_R2, ST_R4, ST_FRIC,
      ST_EX1, ST_EX2, ST_EX3, ST_NZ1, ST_NZ2, ST_NZ3, ST_BAND_CHK, ST_BADDR,
      ST_BRD1, ST_BRD2, ST_BINT, ST_F1, ST_F2, ST_F3, ST_F4, ST_W1, ST_W2,
      ST_W3, ST_W4, ST_W5, ST_OUT1, ST_EMIT
   } st_type;

   typedef struct packed {
      op_type              op;
      logic [BandBits-1:0] band;
   } cmd_type;

   typedef struct packed {
      logic press_zero;
      logic band_en;
      logic x_small;
      logic clr_last;
   } stat_type;

   // arithmetic shift right, truncating toward zero
   function automatic logic signed [63:0] tz_shr(input logic signed [63:0] v,
                                                 input logic [5:0] s);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = m >> s;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [SampleBits-1:0] sat_sig(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd1 <<< (SampleBits - 1);
      hi = hi - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return SampleBits'(hi);
      end else if (v < lo) begin
         return SampleBits'(lo);
      end
      return SampleBits'(v);
   endfunction

   function automatic logic [16:0] q16_sat(input logic [16:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

   function automatic logic [16:0] inj_w(input logic [BandBits-1:0] k);
      logic [16:0] w;
      case (k)
         2'd0:    w = 17'd40632;
         2'd1:    w = 17'd13107;
         2'd2:    w = 17'd7209;
         default: w = 17'd4588;
      endcase
      return w;
   endfunction

   function automatic logic [16:0] out_w(input logic [BandBits-1:0] k);
      logic [16:0] w;
      case (k)
         2'd0:    w = 17'd65536;
         2'd1:    w = 17'd26214;
         2'd2:    w = 17'd14418;
         default: w = 17'd7864;
      endcase
      return w;
   endfunction

endpackage

// ===== sv/banded_waveguide_bow_voice_top.sv =====
// channel  ports                         payload
// request  req_valid / req_ready         start_note, pressure, bow_speed, upper_inject, out_gain
// response rsp_valid / rsp_ready         sample (signed Q4.20)
// csr      csr_psel/penable/pwrite       64-bit registers at 8*index
//
// How long one request takes depends on whether the bow is down and on how many bands are on;
// the 20-step restoring divider of the friction curve and 14 steps per band on the
// single shared multiplier set this.
// start_note adds a clear of the 4096-entry delay lines; the same clear runs after reset,
// during which no request is taken. A finished sample waits in the output register, and
// the next request is taken meanwhile; the block stalls only at the end of that one.
module banded_waveguide_bow_voice_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_start_note,
   input  logic [16:0]        req_pressure,
   input  logic [16:0]        req_bow_speed,
   input  logic [16:0]        req_upper_inject,
   input  logic [16:0]        req_out_gain,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_sample,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   logic [bwbv_pkg::SetupBits-1:0] band_setup_ff [bwbv_pkg::BandCount];
   logic [63:0]                    loop_gains_ff;
   logic [15:0]                    bow_force_ff;
   logic                           csr_wr;
   logic [2:0]                     csr_idx;
   bwbv_pkg::cmd_type              cmd;
   bwbv_pkg::stat_type             stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bwbv_pkg::BandCount; b++) band_setup_ff[b] <= '0;
         loop_gains_ff <= '0;
         bow_force_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            bwbv_pkg::RegBand0:    band_setup_ff[0] <= csr_pwdata[56:0];
            bwbv_pkg::RegBand1:    band_setup_ff[1] <= csr_pwdata[56:0];
            bwbv_pkg::RegBand2:    band_setup_ff[2] <= csr_pwdata[56:0];
            bwbv_pkg::RegBand3:    band_setup_ff[3] <= csr_pwdata[56:0];
            bwbv_pkg::RegLoopGain: loop_gains_ff    <= csr_pwdata;
            bwbv_pkg::RegBowForce: bow_force_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bwbv_pkg::RegBand0:    csr_prdata = 64'(band_setup_ff[0]);
         bwbv_pkg::RegBand1:    csr_prdata = 64'(band_setup_ff[1]);
         bwbv_pkg::RegBand2:    csr_prdata = 64'(band_setup_ff[2]);
         bwbv_pkg::RegBand3:    csr_prdata = 64'(band_setup_ff[3]);
         bwbv_pkg::RegLoopGain: csr_prdata = loop_gains_ff;
         bwbv_pkg::RegBowForce: csr_prdata = 64'(bow_force_ff);
         default:               csr_prdata = '0;
      endcase
   end

   bwbv_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_note (req_start_note),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   bwbv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_pressure     (req_pressure),
      .req_bow_speed    (req_bow_speed),
      .req_upper_inject (req_upper_inject),
      .req_out_gain     (req_out_gain),
      .band_setup       (band_setup_ff),
      .loop_gains       (loop_gains_ff),
      .bow_force        (bow_force_ff),
      .rsp_sample       (rsp_sample)
   );

endmodule

// ===== sv/bwbv_ctrl.sv =====
module bwbv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_start_note,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bwbv_pkg::stat_type   stat,
   output bwbv_pkg::cmd_type    cmd
);

   bwbv_pkg::st_type              state_ff, state_in;
   logic [bwbv_pkg::BandBits-1:0] band_ff, band_in;
   logic [4:0]                    div_ff, div_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bwbv_pkg::ST_INIT_CLR;
         band_ff      <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         band_ff      <= band_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      band_in      = band_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = bwbv_pkg::OP_NONE;
      cmd.band     = band_ff;
      case (state_ff)
         bwbv_pkg::ST_INIT_CLR: begin
            cmd.op = bwbv_pkg::OP_CLEAR;
            if (stat.clr_last) state_in = bwbv_pkg::ST_IDLE;
         end
         bwbv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bwbv_pkg::OP_LOAD;
               band_in  = '0;
               state_in = req_start_note ? bwbv_pkg::ST_NOTE_CLR : bwbv_pkg::ST_PRESS_CHK;
            end
         end
         bwbv_pkg::ST_NOTE_CLR: begin
            cmd.op = bwbv_pkg::OP_CLEAR;
            if (stat.clr_last) state_in = bwbv_pkg::ST_PRESS_CHK;
         end
         bwbv_pkg::ST_PRESS_CHK: begin
            state_in = stat.press_zero ? bwbv_pkg::ST_BAND_CHK : bwbv_pkg::ST_TERM;
         end
         bwbv_pkg::ST_TERM: begin
            cmd.op = bwbv_pkg::OP_TERM;   state_in = bwbv_pkg::ST_SLOPE1;
         end
         bwbv_pkg::ST_SLOPE1: begin
            cmd.op = bwbv_pkg::OP_SLOPE1; state_in = bwbv_pkg::ST_SLOPE2;
         end
         bwbv_pkg::ST_SLOPE2: begin
            cmd.op = bwbv_pkg::OP_SLOPE2; state_in = bwbv_pkg::ST_XLOAD;
         end
         bwbv_pkg::ST_XLOAD: begin
            cmd.op = bwbv_pkg::OP_XLOAD;  state_in = bwbv_pkg::ST_DIVINIT;
         end
         bwbv_pkg::ST_DIVINIT: begin
            cmd.op   = bwbv_pkg::OP_DIVINIT;
            div_in   = '0;
            state_in = stat.x_small ? bwbv_pkg::ST_EX1 : bwbv_pkg::ST_DIVSTEP;
         end
         bwbv_pkg::ST_DIVSTEP: begin
            cmd.op = bwbv_pkg::OP_DIVSTEP;
            div_in = div_ff + 5'd1;
            if (div_ff == bwbv_pkg::DivLast) state_in = bwbv_pkg::ST_R2;
         end
         bwbv_pkg::ST_R2:  begin cmd.op = bwbv_pkg::OP_R2;   state_in = bwbv_pkg::ST_R4;  end
         bwbv_pkg::ST_R4:  begin cmd.op = bwbv_pkg::OP_R4;   state_in = bwbv_pkg::ST_FRIC; end
         bwbv_pkg::ST_FRIC: begin cmd.op = bwbv_pkg::OP_FRIC; state_in = bwbv_pkg::ST_EX1; end
         bwbv_pkg::ST_EX1: begin cmd.op = bwbv_pkg::OP_EX1;  state_in = bwbv_pkg::ST_EX2; end
         bwbv_pkg::ST_EX2: begin cmd.op = bwbv_pkg::OP_EX2;  state_in = bwbv_pkg::ST_EX3; end
         bwbv_pkg::ST_EX3: begin cmd.op = bwbv_pkg::OP_EX3;  state_in = bwbv_pkg::ST_NZ1; end
         bwbv_pkg::ST_NZ1: begin cmd.op = bwbv_pkg::OP_NZ1;  state_in = bwbv_pkg::ST_NZ2; end
         bwbv_pkg::ST_NZ2: begin cmd.op = bwbv_pkg::OP_NZ2;  state_in = bwbv_pkg::ST_NZ3; end
         bwbv_pkg::ST_NZ3: begin
            cmd.op = bwbv_pkg::OP_NZ3; state_in = bwbv_pkg::ST_BAND_CHK;
         end
         bwbv_pkg::ST_BAND_CHK: begin
            if (stat.band_en) begin
               state_in = bwbv_pkg::ST_BADDR;
            end else if (band_ff == bwbv_pkg::BandBits'(bwbv_pkg::BandCount - 1)) begin
               state_in = bwbv_pkg::ST_OUT1;
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         bwbv_pkg::ST_BADDR: begin cmd.op = bwbv_pkg::OP_BADDR; state_in = bwbv_pkg::ST_BRD1; end
         bwbv_pkg::ST_BRD1:  begin cmd.op = bwbv_pkg::OP_BRD1;  state_in = bwbv_pkg::ST_BRD2; end
         bwbv_pkg::ST_BRD2:  begin cmd.op = bwbv_pkg::OP_BRD2;  state_in = bwbv_pkg::ST_BINT; end
         bwbv_pkg::ST_BINT:  begin cmd.op = bwbv_pkg::OP_BINT;  state_in = bwbv_pkg::ST_F1;   end
         bwbv_pkg::ST_F1:    begin cmd.op = bwbv_pkg::OP_F1;    state_in = bwbv_pkg::ST_F2;   end
         bwbv_pkg::ST_F2:    begin cmd.op = bwbv_pkg::OP_F2;    state_in = bwbv_pkg::ST_F3;   end
         bwbv_pkg::ST_F3:    begin cmd.op = bwbv_pkg::OP_F3;    state_in = bwbv_pkg::ST_F4;   end
         bwbv_pkg::ST_F4:    begin cmd.op = bwbv_pkg::OP_F4;    state_in = bwbv_pkg::ST_W1;   end
         bwbv_pkg::ST_W1:    begin cmd.op = bwbv_pkg::OP_W1;    state_in = bwbv_pkg::ST_W2;   end
         bwbv_pkg::ST_W2:    begin cmd.op = bwbv_pkg::OP_W2;    state_in = bwbv_pkg::ST_W3;   end
         bwbv_pkg::ST_W3:    begin cmd.op = bwbv_pkg::OP_W3;    state_in = bwbv_pkg::ST_W4;   end
         bwbv_pkg::ST_W4:    begin cmd.op = bwbv_pkg::OP_W4;    state_in = bwbv_pkg::ST_W5;   end
         bwbv_pkg::ST_W5: begin
            cmd.op = bwbv_pkg::OP_W5;
            if (band_ff == bwbv_pkg::BandBits'(bwbv_pkg::BandCount - 1)) begin
               state_in = bwbv_pkg::ST_OUT1;
            end else begin
               band_in  = band_ff + 1'b1;
               state_in = bwbv_pkg::ST_BAND_CHK;
            end
         end
         bwbv_pkg::ST_OUT1: begin cmd.op = bwbv_pkg::OP_OUT1; state_in = bwbv_pkg::ST_EMIT; end
         bwbv_pkg::ST_EMIT: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = bwbv_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = bwbv_pkg::ST_IDLE;
            end
         end
         default: state_in = bwbv_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== sv/bwbv_dp.sv =====
module bwbv_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bwbv_pkg::cmd_type                    cmd,
   output bwbv_pkg::stat_type                   stat,
   input  logic [16:0]                          req_pressure,
   input  logic [16:0]                          req_bow_speed,
   input  logic [16:0]                          req_upper_inject,
   input  logic [16:0]                          req_out_gain,
   input  logic [bwbv_pkg::SetupBits-1:0]       band_setup [bwbv_pkg::BandCount],
   input  logic [63:0]                          loop_gains,
   input  logic [15:0]                          bow_force,
   output logic signed [23:0]                   rsp_sample
);

   localparam int SB = bwbv_pkg::SampleBits;
   localparam int AB = bwbv_pkg::AddrBits;

   logic [SB-1:0]            dmem [bwbv_pkg::BandCount][bwbv_pkg::DelayDepth];
   logic [SB-1:0]            rdb_ff [bwbv_pkg::BandCount];
   logic signed [SB-1:0]     hist_ff [bwbv_pkg::BandCount][4];

   logic [16:0]              press_ff, inj_ff, gain_ff;
   logic [20:0]              vbow_ff;
   logic [AB-1:0]            clr_ff, wp_ff, i1_ff;
   logic [7:0]               fr_ff;
   logic [31:0]              noise_ff;
   logic signed [20:0]       nz_ff;
   logic signed [27:0]       dv_ff, sig_ff;
   logic [31:0]              x_ff, rem_ff;
   logic [19:0]              q_ff;
   logic [20:0]              fric_ff;
   logic signed [31:0]       ex_ff;
   logic signed [63:0]       acc_ff;
   logic signed [SB-1:0]     d_ff, y_ff;
   logic signed [24:0]       t_ff;
   logic signed [67:0]       prod_ff;
   logic signed [23:0]       rsp_sample_ff;

   logic signed [33:0]       ma, mb;
   logic                     mul_en;
   logic signed [63:0]       p;
   logic [31:0]              noise_nx;
   logic signed [25:0]       vsum;
   logic [27:0]              dv_mag;
   logic [bwbv_pkg::SetupBits-1:0] cfg;
   logic [19:0]              lenc, rp;
   logic [17:0]              b0;
   logic signed [19:0]       a1x4, a2;
   logic [15:0]              fb;
   logic [AB-1:0]            raddr;
   logic [SB-1:0]            rd;
   logic signed [SB-1:0]     wv, y_nx;
   logic [32:0]              rem2;
   logic signed [63:0]       t64;

   assign p   = prod_ff[63:0];
   assign cfg = band_setup[cmd.band];
   assign rd  = rdb_ff[cmd.band];
   assign fb  = loop_gains[16*cmd.band +: 16];
   assign b0  = cfg[38:21];
   assign a1x4 = {cfg[56:39], 2'b00};
   assign a2  = 20'sh40000 - $signed({1'b0, b0, 1'b0});
   assign lenc = (cfg[20:1] > bwbv_pkg::LenMax) ? bwbv_pkg::LenMax : cfg[20:1];
   assign rp   = {wp_ff, 8'h00} - lenc;
   assign raddr = (cmd.op == bwbv_pkg::OP_BADDR) ? rp[19:8] : i1_ff;
   assign dv_mag = dv_ff[27] ? 28'(-dv_ff) : 28'(dv_ff);
   assign rem2 = {rem_ff, 1'b0};
   assign rsp_sample = rsp_sample_ff;

   always_comb begin
      noise_nx = noise_ff;
      noise_nx = noise_nx ^ (noise_nx << 13);
      noise_nx = noise_nx ^ (noise_nx >> 17);
      noise_nx = noise_nx ^ (noise_nx << 5);
      vsum = '0;
      for (int k = 0; k < bwbv_pkg::BandCount; k++) begin
         if (band_setup[k][0]) vsum = vsum + 26'(hist_ff[k][2]);
      end
   end

   always_comb begin
      stat.press_zero = (press_ff == '0);
      stat.band_en    = cfg[0];
      stat.x_small    = (x_ff <= 32'd1048576);
      stat.clr_last   = (clr_ff == AB'(bwbv_pkg::DelayDepth - 1));
   end

   // shared multiplier operand select
   always_comb begin
      ma     = '0;
      mb     = '0;
      mul_en = 1'b1;
      t64    = '0;
      case (cmd.op)
         bwbv_pkg::OP_TERM: begin ma = 34'sd29491; mb = 34'(press_ff); end
         bwbv_pkg::OP_SLOPE1: begin
            ma = 34'(bow_force);
            mb = 34'(17'd36045 + p[32:16]);
         end
         bwbv_pkg::OP_SLOPE2: begin
            ma = 34'(dv_mag);
            mb = 34'(20'd327680 - {1'b0, p[32:16], 2'b00});
         end
         bwbv_pkg::OP_R2:  begin ma = 34'(q_ff); mb = 34'(q_ff); end
         bwbv_pkg::OP_R4:  begin ma = 34'(p[40:20]); mb = 34'(p[40:20]); end
         bwbv_pkg::OP_EX1: begin ma = 34'(dv_ff); mb = 34'(fric_ff); end
         bwbv_pkg::OP_EX2: begin
            ma = 34'(bwbv_pkg::tz_shr(p, 6'd20)); mb = 34'(press_ff);
         end
         bwbv_pkg::OP_EX3: begin ma = 34'(nz_ff); mb = 34'sd3932; end
         bwbv_pkg::OP_NZ1: begin
            ma = 34'(bwbv_pkg::tz_shr(p, 6'd16)); mb = 34'(press_ff);
         end
         bwbv_pkg::OP_NZ2: begin
            ma = 34'(bwbv_pkg::tz_shr(p, 6'd16)); mb = 34'(fric_ff);
         end
         bwbv_pkg::OP_BRD1: begin
            ma = 34'($signed(rd)); mb = 34'(9'd256 - {1'b0, fr_ff});
         end
         bwbv_pkg::OP_BRD2: begin ma = 34'($signed(rd)); mb = 34'(fr_ff); end
         bwbv_pkg::OP_F1: begin
            ma = 34'(b0);
            mb = 34'(25'(d_ff) - 25'(hist_ff[cmd.band][1]));
         end
         bwbv_pkg::OP_F2: begin ma = 34'(a1x4); mb = 34'(hist_ff[cmd.band][2]); end
         bwbv_pkg::OP_F3: begin ma = 34'(a2);   mb = 34'(hist_ff[cmd.band][3]); end
         bwbv_pkg::OP_W1: begin ma = 34'(y_ff); mb = 34'(fb); end
         bwbv_pkg::OP_W2: begin ma = 34'(ex_ff); mb = 34'(bwbv_pkg::inj_w(cmd.band)); end
         bwbv_pkg::OP_W3: begin
            ma = 34'(bwbv_pkg::tz_shr(p, 6'd16));
            mb = (cmd.band == '0) ? 34'sd65536 : 34'(inj_ff);
         end
         bwbv_pkg::OP_W4: begin ma = 34'(y_ff); mb = 34'(bwbv_pkg::out_w(cmd.band)); end
         bwbv_pkg::OP_OUT1: begin ma = 34'(sig_ff); mb = 34'(gain_ff); end
         default: mul_en = 1'b0;
      endcase
      t64 = 64'(t_ff) + bwbv_pkg::tz_shr(p, 6'd16);
      wv  = bwbv_pkg::sat_sig(t64);
      y_nx = bwbv_pkg::sat_sig(bwbv_pkg::tz_shr(acc_ff - p, 6'd18));
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= ma * mb;
   end

   // delay lines: one bank per band, cleared in parallel
   always_ff @(posedge clock) begin
      for (int b = 0; b < bwbv_pkg::BandCount; b++) begin
         if (cmd.op == bwbv_pkg::OP_CLEAR) begin
            dmem[b][clr_ff] <= '0;
         end else if (cmd.op == bwbv_pkg::OP_W4 && cmd.band == bwbv_pkg::BandBits'(b)) begin
            dmem[b][wp_ff] <= wv;
         end
         rdb_ff[b] <= dmem[b][raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         wp_ff    <= '0;
         noise_ff <= bwbv_pkg::NoiseSeed;
      end else begin
         case (cmd.op)
            bwbv_pkg::OP_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               wp_ff  <= '0;
            end
            bwbv_pkg::OP_TERM: noise_ff <= noise_nx;
            bwbv_pkg::OP_EMIT: wp_ff    <= wp_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         bwbv_pkg::OP_LOAD: begin
            press_ff <= bwbv_pkg::q16_sat(req_pressure);
            vbow_ff  <= {bwbv_pkg::q16_sat(req_bow_speed), 4'h0};
            inj_ff   <= bwbv_pkg::q16_sat(req_upper_inject);
            gain_ff  <= bwbv_pkg::q16_sat(req_out_gain);
            ex_ff    <= '0;
            sig_ff   <= '0;
         end
         bwbv_pkg::OP_CLEAR: begin
            for (int b = 0; b < bwbv_pkg::BandCount; b++) begin
               for (int j = 0; j < 4; j++) hist_ff[b][j] <= '0;
            end
         end
         bwbv_pkg::OP_TERM: begin
            dv_ff <= 28'($signed({1'b0, vbow_ff})) - 28'(vsum);
            nz_ff <= 21'(bwbv_pkg::tz_shr(64'($signed(noise_nx)), 6'd11));
         end
         bwbv_pkg::OP_XLOAD: x_ff <= p[47:16] + 32'd786432;
         bwbv_pkg::OP_DIVINIT: begin
            fric_ff <= 21'd1048576;
            rem_ff  <= 32'd1048576;
            q_ff    <= '0;
         end
         bwbv_pkg::OP_DIVSTEP: begin
            if (rem2 >= {1'b0, x_ff}) begin
               rem_ff <= 32'(rem2 - {1'b0, x_ff});
               q_ff   <= {q_ff[18:0], 1'b1};
            end else begin
               rem_ff <= rem2[31:0];
               q_ff   <= {q_ff[18:0], 1'b0};
            end
         end
         bwbv_pkg::OP_FRIC: fric_ff <= p[40:20];
         bwbv_pkg::OP_EX3:  ex_ff <= 32'(bwbv_pkg::tz_shr(p, 6'd16));
         bwbv_pkg::OP_NZ3:  ex_ff <= ex_ff + 32'(bwbv_pkg::tz_shr(p, 6'd20));
         bwbv_pkg::OP_BADDR: begin
            i1_ff <= rp[19:8] + 1'b1;
            fr_ff <= rp[7:0];
         end
         bwbv_pkg::OP_BRD2: acc_ff <= p;
         bwbv_pkg::OP_BINT: d_ff <= SB'(bwbv_pkg::tz_shr(acc_ff + p, 6'd8));
         bwbv_pkg::OP_F2:   acc_ff <= p;
         bwbv_pkg::OP_F3:   acc_ff <= acc_ff - p;
         bwbv_pkg::OP_F4: begin
            y_ff <= y_nx;
            hist_ff[cmd.band][1] <= hist_ff[cmd.band][0];
            hist_ff[cmd.band][0] <= d_ff;
            hist_ff[cmd.band][3] <= hist_ff[cmd.band][2];
            hist_ff[cmd.band][2] <= y_nx;
         end
         bwbv_pkg::OP_W2: t_ff   <= 25'(bwbv_pkg::tz_shr(p, 6'd16));
         bwbv_pkg::OP_W5: sig_ff <= sig_ff + 28'(bwbv_pkg::tz_shr(p, 6'd16));
         bwbv_pkg::OP_EMIT: rsp_sample_ff <= bwbv_pkg::sat_sig(bwbv_pkg::tz_shr(p, 6'd16));
         default: ;
      endcase
   end

endmodule
